// ===== sv/mabs_pkg.sv =====
// Shared types, codes and constants of the multi-axis brake sequencer.
package mabs_pkg;

    localparam int MAX_AXES            = 5;
    localparam int DEFAULT_NUM_AXES    = 5;
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int TIMEOUT_WIDTH       = 16;
    localparam int AXIS_WIDTH          = 3;
    localparam int NUM_STRAT_REGS      = 5;
    localparam int APB_ADDR_WIDTH      = 5;
    localparam int APB_DATA_WIDTH      = 32;
    localparam int S_TDATA_WIDTH       = 8;
    localparam int M_TDATA_WIDTH       = 16;

    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd5;
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        OP_SET_BRAKE     = 3'd0,
        OP_ENABLE        = 3'd1,
        OP_DISABLE       = 3'd2,
        OP_MOTION_START  = 3'd3,
        OP_MOTION_STOP   = 3'd4,
        OP_TICK          = 3'd5,
        OP_FORCE_TIMEOUT = 3'd6,
        OP_IGNORE        = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        STRAT_ON_DISABLE = 2'd0,
        STRAT_ON_ESTOP   = 2'd1,
        STRAT_ON_IDLE    = 2'd2,
        STRAT_MANUAL     = 2'd3
    } strategy_t;

    // Command from the sequencer core to one axis lane.
    typedef struct packed {
        logic    fire;
        logic    sel;
        opcode_t op;
        logic    engage;
    } lane_cmd_t;

    // Outcome of one request at one axis lane.
    typedef struct packed {
        logic brake;
        logic engaged_ev;
        logic released_ev;
    } lane_res_t;

endpackage

// ===== sv/mabs_apb_regs.sv =====
// APB configuration registers: per-axis brake strategies and the idle timeout.
module mabs_apb_regs
    import mabs_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]       paddr,
    input  logic [APB_DATA_WIDTH-1:0]       pwdata,
    output logic [APB_DATA_WIDTH-1:0]       prdata,
    output logic                            pready,
    output strategy_t [NUM_STRAT_REGS-1:0]  strategy,
    output logic [TIMEOUT_WIDTH-1:0]        idle_timeout
);

    strategy_t [NUM_STRAT_REGS-1:0] strategy_reg;
    logic [TIMEOUT_WIDTH-1:0]       timeout_reg;
    logic [2:0]                     reg_index;
    logic                           wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STRAT_REGS; i++)
            begin
                strategy_reg[i] <= STRAT_MANUAL;
            end
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_index == REG_IDLE_TIMEOUT)
            begin
                timeout_reg <= pwdata[TIMEOUT_WIDTH-1:0];
            end
            else if (reg_index < REG_IDLE_TIMEOUT)
            begin
                strategy_reg[reg_index] <= strategy_t'(pwdata[1:0]);
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_IDLE_TIMEOUT)
        begin
            prdata = {{(APB_DATA_WIDTH-TIMEOUT_WIDTH){1'b0}}, timeout_reg};
        end
        else if (reg_index < REG_IDLE_TIMEOUT)
        begin
            prdata = {{(APB_DATA_WIDTH-2){1'b0}}, strategy_reg[reg_index]};
        end
    end

    assign strategy     = strategy_reg;
    assign idle_timeout = timeout_reg;

endmodule

// ===== sv/mabs_axis_lane.sv =====
// One axis: brake state, idle countdown and the per-request update.
module mabs_axis_lane
    import mabs_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_cmd_t              cmd,
    input  strategy_t              strategy,
    input  logic [COUNT_WIDTH-1:0] arm_value,
    output lane_res_t              res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic                   brake_reg, brake_next;
    logic                   armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   eng_ev, rel_ev;
    logic                   is_idle;

    assign is_idle = (strategy == STRAT_ON_IDLE);

    always_comb
    begin
        brake_next = brake_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        eng_ev     = 1'b0;
        rel_ev     = 1'b0;
        if (cmd.fire && cmd.op == OP_TICK)
        begin
            // Count down; on expiry an idle-strategy axis engages, others park at zero.
            if (armed_reg && cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE && is_idle)
                begin
                    armed_next = 1'b0;
                    if (!brake_reg)
                    begin
                        brake_next = 1'b1;
                        eng_ev     = 1'b1;
                    end
                end
            end
        end
        else if (cmd.fire && cmd.sel)
        begin
            unique case (cmd.op)
                OP_SET_BRAKE:
                begin
                    brake_next = cmd.engage;
                    eng_ev     = cmd.engage;
                    rel_ev     = !cmd.engage;
                    if (is_idle)
                    begin
                        armed_next = !cmd.engage;
                        cnt_next   = cmd.engage ? '0 : arm_value;
                    end
                end
                OP_ENABLE:
                begin
                    if (strategy == STRAT_ON_DISABLE)
                    begin
                        brake_next = 1'b0;
                        rel_ev     = 1'b1;
                    end
                    else if (is_idle)
                    begin
                        brake_next = 1'b0;
                        rel_ev     = brake_reg;
                        armed_next = 1'b0;
                        cnt_next   = '0;
                    end
                end
                OP_DISABLE:
                begin
                    if (strategy == STRAT_ON_DISABLE)
                    begin
                        brake_next = 1'b1;
                        eng_ev     = 1'b1;
                    end
                    else if (is_idle)
                    begin
                        armed_next = 1'b1;
                        cnt_next   = arm_value;
                    end
                end
                OP_MOTION_START:
                begin
                    // Disarm always; an engaged idle-strategy brake releases and re-arms.
                    armed_next = 1'b0;
                    cnt_next   = '0;
                    if (brake_reg && is_idle)
                    begin
                        brake_next = 1'b0;
                        rel_ev     = 1'b1;
                        armed_next = 1'b1;
                        cnt_next   = arm_value;
                    end
                end
                OP_MOTION_STOP:
                begin
                    if (is_idle)
                    begin
                        armed_next = 1'b1;
                        cnt_next   = arm_value;
                    end
                end
                OP_FORCE_TIMEOUT:
                begin
                    if (is_idle && armed_reg)
                    begin
                        armed_next = 1'b0;
                        cnt_next   = '0;
                        if (!brake_reg)
                        begin
                            brake_next = 1'b1;
                            eng_ev     = 1'b1;
                        end
                    end
                end
                OP_TICK, OP_IGNORE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_reg <= 1'b1;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            brake_reg <= brake_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign res.brake       = brake_next;
    assign res.engaged_ev  = eng_ev;
    assign res.released_ev = rel_ev;

endmodule

// ===== sv/multi_axis_brake_sequencer_core.sv =====
// Top level of the multi-axis brake sequencer: stream ports, APB port and axis lanes.
//
// Usage: each request on the slave stream (s_tvalid/s_tready/s_tdata) names an
// opcode, a target axis and, for set brake, the requested brake value. Every
// request yields exactly one result on the master stream (m_tvalid/m_tready/
// m_tdata): a status bit, the mask of released brakes after the request, and
// masks of engaged and released events caused by it.
// Throughput is one request per cycle while the receiver keeps m_tready high. A
// request is captured in an input register; when the output register is free,
// all axis lanes update in parallel and the result lands in the output register.
// The lanes' state registers close a loop through the lane logic, which is what
// limits the rate to one request per clock.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more request; s_tready then drops until the
// result is taken. Ready on the slave side follows m_tready combinationally.
// Reset (rst_n low, asynchronous) engages all brakes, disarms all countdowns,
// sets every strategy to manual and the idle timeout to 1000 ticks, and
// empties both registers. Write configuration over APB only while idle.
module multi_axis_brake_sequencer_core
    import mabs_pkg::*;
#(
    parameter int NUM_AXES    = DEFAULT_NUM_AXES,
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // APB configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    // request stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [2:0] opcode, [5:3] axis_index, [6] engage_request, [7] zero
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] status, [5:1] released_mask, [10:6] engaged_events, [15:11] released_events
    output logic [M_TDATA_WIDTH-1:0]  m_tdata
);

    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    strategy_t [NUM_STRAT_REGS-1:0] strategy;
    logic [TIMEOUT_WIDTH-1:0]       idle_timeout;
    logic [32:0]                    arm_wide;
    logic [COUNT_WIDTH-1:0]         arm_value;

    logic                     in_valid_reg;
    opcode_t                  op_reg;
    logic [AXIS_WIDTH-1:0]    axis_reg;
    logic                     engage_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                     advance;
    logic                     axis_ok;
    logic                     status;

    lane_res_t [NUM_AXES-1:0] lane_res;
    logic [MAX_AXES-1:0]      rel_mask, eng_mask, relev_mask;

    mabs_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .strategy     (strategy),
        .idle_timeout (idle_timeout)
    );

    // Arm value: a zero timeout counts as one tick, clip to the counter range.
    always_comb
    begin
        arm_wide = {{(33-TIMEOUT_WIDTH){1'b0}}, idle_timeout};
        if (arm_wide == '0)
        begin
            arm_wide = 33'd1;
        end
        if (arm_wide > COUNT_MAX)
        begin
            arm_wide = COUNT_MAX;
        end
    end
    assign arm_value = arm_wide[COUNT_WIDTH-1:0];

    // Advance the held request into the result register when that register frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg     <= opcode_t'(s_tdata[2:0]);
            axis_reg   <= s_tdata[5:3];
            engage_reg <= s_tdata[6];
        end
    end

    assign axis_ok = (axis_reg < AXIS_WIDTH'(NUM_AXES));
    assign status  = !axis_ok && (op_reg != OP_TICK) && (op_reg != OP_IGNORE);

    for (genvar gi = 0; gi < NUM_AXES; gi++)
    begin : g_lane
        lane_cmd_t cmd;

        assign cmd.fire   = advance;
        assign cmd.sel    = axis_ok && (axis_reg == AXIS_WIDTH'(gi));
        assign cmd.op     = op_reg;
        assign cmd.engage = engage_reg;

        mabs_axis_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .strategy  (strategy[gi]),
            .arm_value (arm_value),
            .res       (lane_res[gi])
        );
    end

    // Gather lane outcomes; axes beyond NUM_AXES read as zero.
    always_comb
    begin
        rel_mask   = '0;
        eng_mask   = '0;
        relev_mask = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            rel_mask[i]   = !lane_res[i].brake;
            eng_mask[i]   = lane_res[i].engaged_ev;
            relev_mask[i] = lane_res[i].released_ev;
        end
        out_data_next = {relev_mask, eng_mask, rel_mask, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/mabs_checker.sv =====
// Port-level checks of the brake sequencer result stream, bound to the top level.
module mabs_checker
    import mabs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata
);

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop all events on an invalid-axis request.
    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[15:6] == 10'd0)
        else $error("events reported with invalid-axis status");

    // An engaged event leaves that brake engaged.
    a_engaged_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:6] & m_tdata[5:1]) == 5'd0)
        else $error("engaged event on a released brake");

    // A released event leaves that brake released.
    a_released_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:11] & ~m_tdata[5:1]) == 5'd0)
        else $error("released event on an engaged brake");

endmodule

bind multi_axis_brake_sequencer_core mabs_checker u_mabs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
